@@ src/upd_pkg.sv @@
package upd_pkg;

	localparam logic [7:0] PCT_CHAR = 8'h25;
	localparam int unsigned ENTRY_BYTES = 3;

	// what is held back waiting for more input
	typedef enum logic [2:0] {
		PEND_NONE = 3'b001,
		PEND_PCT  = 3'b010,
		PEND_DIG  = 3'b100
	} pend_t;

	// output bytes caused by one input word
	typedef struct packed {
		logic [ENTRY_BYTES-1:0][7:0] bytes;
		logic [1:0]                  last_idx;
		logic                        last;
	} entry_t;

	function automatic logic is_hex(input logic [7:0] c);
		logic r;
		r = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
		return r;
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] d;
		if (c inside {[8'h30:8'h39]}) begin
			d = c - 8'h30;
		end else if (c inside {[8'h41:8'h46]}) begin
			d = c - 8'h37;
		end else begin
			d = c - 8'h57;
		end
		return d[3:0];
	endfunction

endpackage

@@ src/upd_front.sv @@
module upd_front
	import upd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       fifo_full,
	output logic       push,
	output entry_t     entry
);

	pend_t      pend_q;
	pend_t      pend_nxt;
	logic [7:0] held_q;
	logic [7:0] held_nxt;
	logic [1:0] n;
	logic       accept;
	logic       b_hex;
	logic       b_pct;

	assign in_stall = fifo_full;
	assign accept   = in_valid && !fifo_full;
	assign b_hex    = is_hex(in_byte);
	assign b_pct    = (in_byte == PCT_CHAR);

	always_comb begin
		n        = 2'd0;
		pend_nxt = PEND_NONE;
		held_nxt = held_q;
		entry    = '0;
		entry.last = in_last;
		case (pend_q)
			PEND_PCT: begin
				if (b_hex) begin
					pend_nxt = PEND_DIG;
					held_nxt = in_byte;
				end else begin
					entry.bytes[0] = PCT_CHAR;
					if (b_pct) begin
						pend_nxt = PEND_PCT;
						n        = 2'd1;
					end else begin
						entry.bytes[1] = in_byte;
						n              = 2'd2;
					end
				end
			end
			PEND_DIG: begin
				if (b_hex) begin
					entry.bytes[0] = {hex_val(held_q), hex_val(in_byte)};
					n              = 2'd1;
				end else begin
					entry.bytes[0] = PCT_CHAR;
					entry.bytes[1] = held_q;
					if (b_pct) begin
						pend_nxt = PEND_PCT;
						n        = 2'd2;
					end else begin
						entry.bytes[2] = in_byte;
						n              = 2'd3;
					end
				end
			end
			default: begin
				if (b_pct) begin
					pend_nxt = PEND_PCT;
				end else begin
					entry.bytes[0] = in_byte;
					n              = 2'd1;
				end
			end
		endcase

		// end of string flushes whatever is still held, raw
		if (in_last) begin
			if (pend_nxt == PEND_PCT) begin
				entry.bytes[n] = PCT_CHAR;
				n              = n + 2'd1;
			end else if (pend_nxt == PEND_DIG) begin
				entry.bytes[0] = PCT_CHAR;
				entry.bytes[1] = held_nxt;
				n              = 2'd2;
			end
			pend_nxt = PEND_NONE;
		end
		entry.last_idx = n - 2'd1;
	end

	assign push = accept && (n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_NONE;
			held_q <= '0;
		end else if (accept) begin
			pend_q <= pend_nxt;
			held_q <= held_nxt;
		end
	end

	a_held_is_hex: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q == PEND_DIG) |-> is_hex(held_q))
		else $error("held digit is not hex");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_last) |=> (pend_q == PEND_NONE))
		else $error("hold survives end of string");

	a_last_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_last) |-> push)
		else $error("end of string produced no word");

endmodule

@@ src/upd_fifo.sv @@
module upd_fifo
	import upd_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	output logic   full,
	input  logic   pop,
	output entry_t head,
	output logic   empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");

endmodule

@@ src/upd_back.sv @@
module upd_back
	import upd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  entry_t     head,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       string_end
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_end_q;
	logic       string_end_q;
	logic       take;
	logic       at_end;

	assign take   = !empty && (!out_valid_q || !out_stall);
	assign at_end = (idx_q == head.last_idx);
	assign pop    = take && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (take) begin
			out_valid_q <= 1'b1;
			idx_q       <= at_end ? 2'd0 : idx_q + 2'd1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q   <= head.bytes[idx_q];
			run_end_q    <= at_end;
			string_end_q <= at_end && head.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign run_end    = run_end_q;
	assign string_end = string_end_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd3)
		else $error("byte index out of range");

endmodule

@@ src/uri_percent_decoder.sv @@
// Percent decoder for an encoded string, one byte per word.
// Input channel: in_valid / in_stall with in_byte and in_last (final byte of
// the string). Output channel: out_valid / out_stall with out_byte, run_end
// (last byte caused by an input word) and string_end (final byte of string).
// "%xx" with two hex digits becomes one byte; a '%' not followed by two hex
// digits goes out raw and the following bytes are looked at again.
// An input word is classified in the cycle it is accepted and up to three
// output bytes are written as one entry into a queue of FIFO_DEPTH entries.
// The drain side sends one byte per cycle while out_stall is low, from the
// queue head into the output register. Input is taken every cycle while the
// queue has room; words that only extend a pending '%' produce no entry.
// Sustained rate is one input word per cycle while out_stall is low, set
// by the one-byte-per-cycle drain, since output never outgrows input over
// a whole string.
// A stall on the output holds the output register; the queue then fills
// and in_stall rises once it is full.
// Reset empties the queue, drops any held '%' or digit, clears out_valid.
module uri_percent_decoder
	import upd_pkg::*;
#(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       string_end
);

	logic   push;
	logic   pop;
	logic   full;
	logic   empty;
	entry_t wr_entry;
	entry_t head;

	upd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.fifo_full (full),
		.push      (push),
		.entry     (wr_entry)
	);

	upd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	upd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.string_end (string_end)
	);

endmodule
